/* src/pta_pkg.sv */
// shared types for the palindromic tree append block
// transfer payloads and the command/status groups between controller and datapath
package pta_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned ResW    = 13;

  typedef struct packed {
    logic               opcode;
    logic [LetterW-1:0] letter;
  } in_t;

  typedef struct packed {
    logic [ResW-1:0] suffix_palindrome_length;
    logic [ResW-1:0] suffix_node;
    logic            node_created;
    logic            store_full;
  } out_t;

  localparam logic OpAppend = 1'b0;
  localparam logic OpClear  = 1'b1;

  typedef struct packed {
    logic wipe;
    logic capture;
    logic clear;
    logic res_last;
    logic res_full;
    logic append;
    logic walk_adv;
    logic walk_len;
    logic cur_save;
    logic child_chk;
    logic node_new;
    logic node_old;
    logic walk2_start;
    logic link_wr;
    logic fin_load;
  } cmd_t;

  typedef struct packed {
    logic wipe_done;
    logic op_clear;
    logic bad_letter;
    logic full;
    logic match;
    logic create;
    logic cur_odd;
  } sts_t;

endpackage

/* src/pta_datapath.sv */
// datapath: letter store, node tables, child table, walk registers, result register
// depends on pta_pkg; driven by pta_ctrl commands
module pta_datapath import pta_pkg::*; #(
  parameter int unsigned MAX_LEN  = 4096,
  parameter int unsigned ALPHABET = 26
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output out_t out_data_o
);

  localparam int unsigned NS = MAX_LEN + 2;
  localparam int unsigned NW = $clog2(NS);
  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam int unsigned LW = PW + 1;
  localparam int unsigned IW = PW + 2;
  localparam int unsigned CD = NS * ALPHABET;
  localparam int unsigned CW = $clog2(CD);

  localparam logic [NW-1:0] NodeEven = NW'(0);
  localparam logic [NW-1:0] NodeOdd  = NW'(1);

  logic               op_q;
  logic [LetterW-1:0] let_q;
  logic [PW-1:0]      pos_q;
  logic [NW-1:0]      cnt_q, last_q;
  logic signed [LW-1:0] last_len_q;
  logic [NW-1:0]      x_q, cur_q, curlink_q, child_q, now_q;
  logic signed [LW-1:0] xlen_q, curlen_q;
  logic               inr_q;
  logic [NW-1:0]      res_node_q;
  logic signed [LW-1:0] res_len_q;
  logic               res_created_q, res_full_q;
  out_t               out_q;
  logic [CW-1:0]      wipe_q;

  logic [LetterW-1:0] lstore [MAX_LEN+1];
  logic [NW-1:0]      ctab   [CD];
  logic signed [LW-1:0] nlen [NS];
  logic [NW-1:0]      nlink  [NS];
  logic [NW-1:0]      npar   [NS];
  logic [LetterW-1:0] nlet   [NS];

  logic [LetterW-1:0] lstore_rd_q, nlet_rd_q;
  logic [NW-1:0]      ctab_rd_q, nlink_rd_q, npar_rd_q;
  logic signed [LW-1:0] nlen_rd_q;

  logic signed [IW-1:0] idx;
  logic [NW-1:0]      lnk, len_addr, now_new, link_data, ctab_wd;
  logic signed [LW-1:0] xlen_next, curlen2;
  logic [CW-1:0]      caddr_rd, caddr_wr, ctab_wa;
  logic               child_valid, room;

  assign idx = $signed({2'b00, pos_q}) - IW'(xlen_q) - IW'(1);
  assign lnk = (x_q == NodeEven) ? NodeOdd : (x_q == NodeOdd) ? NodeEven : nlink_rd_q;
  assign len_addr = cmd_i.walk2_start ? curlink_q : lnk;
  assign xlen_next = (x_q == NodeEven) ? LW'(0) : (x_q == NodeOdd) ? -LW'(1) : nlen_rd_q;
  assign caddr_rd = CW'(x_q) * CW'(ALPHABET) + CW'(let_q);
  assign caddr_wr = CW'(cur_q) * CW'(ALPHABET) + CW'(let_q);
  assign now_new = cnt_q + NW'(1);
  assign curlen2 = curlen_q + LW'(2);
  assign room = ((NW+1)'(cnt_q) + (NW+1)'(1)) < (NW+1)'(NS);
  assign child_valid = (child_q != NodeEven) && (child_q <= cnt_q) &&
                       (npar_rd_q == cur_q) && (nlet_rd_q == let_q);
  assign link_data = cmd_i.link_wr ? ctab_rd_q : NodeEven;
  // the clearing pass after reset shares the child table write port
  assign ctab_wa = cmd_i.wipe ? wipe_q : caddr_wr;
  assign ctab_wd = cmd_i.wipe ? NodeEven : now_new;

  always_comb begin
    sts_o.wipe_done  = (wipe_q == CW'(CD - 1));
    sts_o.op_clear   = (op_q == OpClear);
    sts_o.bad_letter = (32'(let_q) >= ALPHABET);
    sts_o.full       = (pos_q == PW'(MAX_LEN));
    sts_o.match      = inr_q && ((x_q == NodeOdd) || (lstore_rd_q == let_q));
    sts_o.create     = !child_valid && room;
    sts_o.cur_odd    = (cur_q == NodeOdd);
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      lstore[pos_q + PW'(1)] <= let_q;
    end
    lstore_rd_q <= lstore[PW'(idx)];
    if (cmd_i.wipe || cmd_i.node_new) begin
      ctab[ctab_wa] <= ctab_wd;
    end
    if (cmd_i.node_new) begin
      nlen[now_new]  <= curlen2;
      npar[now_new]  <= cur_q;
      nlet[now_new]  <= let_q;
    end
    ctab_rd_q <= ctab[caddr_rd];
    nlen_rd_q <= nlen[len_addr];
    npar_rd_q <= npar[ctab_rd_q];
    nlet_rd_q <= nlet[ctab_rd_q];
    if (cmd_i.link_wr || (cmd_i.node_new && cur_q == NodeOdd)) begin
      nlink[cmd_i.link_wr ? now_q : now_new] <= link_data;
    end
    nlink_rd_q <= nlink[x_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      cnt_q      <= NodeOdd;
      last_q     <= NodeEven;
      last_len_q <= '0;
      wipe_q     <= '0;
    end else if (cmd_i.clear) begin
      pos_q      <= '0;
      cnt_q      <= NodeOdd;
      last_q     <= NodeEven;
      last_len_q <= '0;
    end else begin
      if (cmd_i.wipe) wipe_q <= wipe_q + CW'(1);
      if (cmd_i.append) pos_q <= pos_q + PW'(1);
      if (cmd_i.node_new) begin
        cnt_q      <= now_new;
        last_q     <= now_new;
        last_len_q <= curlen2;
      end else if (cmd_i.node_old) begin
        last_q     <= child_valid ? child_q : NodeEven;
        last_len_q <= child_valid ? curlen2 : LW'(0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    inr_q <= (idx >= IW'(1)) || (x_q == NodeOdd);
    if (cmd_i.capture) begin
      op_q  <= in_data_i.opcode;
      let_q <= in_data_i.letter;
    end
    if (cmd_i.append) begin
      x_q    <= last_q;
      xlen_q <= last_len_q;
    end else if (cmd_i.walk_adv || cmd_i.walk2_start) begin
      x_q <= len_addr;
    end else if (cmd_i.walk_len) begin
      xlen_q <= xlen_next;
    end
    if (cmd_i.cur_save) begin
      cur_q     <= x_q;
      curlen_q  <= xlen_q;
      curlink_q <= lnk;
    end
    if (cmd_i.child_chk) child_q <= ctab_rd_q;
    if (cmd_i.node_new) now_q <= now_new;
    if (cmd_i.clear) begin
      res_node_q    <= NodeEven;
      res_len_q     <= '0;
      res_created_q <= 1'b0;
      res_full_q    <= 1'b0;
    end else if (cmd_i.res_last) begin
      res_node_q    <= last_q;
      res_len_q     <= last_len_q;
      res_created_q <= 1'b0;
      res_full_q    <= cmd_i.res_full;
    end else if (cmd_i.node_new) begin
      res_node_q    <= now_new;
      res_len_q     <= curlen2;
      res_created_q <= 1'b1;
      res_full_q    <= 1'b0;
    end else if (cmd_i.node_old) begin
      res_node_q    <= child_valid ? child_q : NodeEven;
      res_len_q     <= child_valid ? curlen2 : LW'(0);
      res_created_q <= 1'b0;
      res_full_q    <= 1'b0;
    end
    if (cmd_i.fin_load) begin
      out_q.suffix_palindrome_length <= res_len_q[LW-1] ? '0 : ResW'(res_len_q[LW-2:0]);
      out_q.suffix_node              <= ResW'(res_node_q);
      out_q.node_created             <= res_created_q;
      out_q.store_full               <= res_full_q;
    end
  end

  assign out_data_o = out_q;

endmodule

/* src/pta_ctrl.sv */
// controller: sequences the suffix-link walks, node creation and result transfer
// depends on pta_pkg
module pta_ctrl import pta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StDec  = 4'd1;
  localparam logic [3:0] StWReq = 4'd2;
  localparam logic [3:0] StWCmp = 4'd3;
  localparam logic [3:0] StWLen = 4'd4;
  localparam logic [3:0] StCRd  = 4'd5;
  localparam logic [3:0] StCVal = 4'd6;
  localparam logic [3:0] StURd  = 4'd7;
  localparam logic [3:0] StFin  = 4'd8;
  localparam logic [3:0] StWipe = 4'd9;

  logic [3:0] state_q, state_d;
  logic       phase2_q, phase2_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    phase2_d    = phase2_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      // zero the child table once after reset
      StWipe: begin
        cmd_o.wipe = 1'b1;
        if (sts_i.wipe_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StDec;
        end
      end
      StDec: begin
        state_d = StFin;
        if (sts_i.op_clear) begin
          cmd_o.clear = 1'b1;
        end else if (sts_i.bad_letter) begin
          cmd_o.res_last = 1'b1;
        end else if (sts_i.full) begin
          cmd_o.res_last = 1'b1;
          cmd_o.res_full = 1'b1;
        end else begin
          cmd_o.append = 1'b1;
          phase2_d     = 1'b0;
          state_d      = StWReq;
        end
      end
      StWReq: state_d = StWCmp;
      StWCmp: begin
        if (sts_i.match) begin
          if (phase2_q) begin
            state_d = StURd;
          end else begin
            cmd_o.cur_save = 1'b1;
            state_d        = StCRd;
          end
        end else begin
          cmd_o.walk_adv = 1'b1;
          state_d        = StWLen;
        end
      end
      StWLen: begin
        cmd_o.walk_len = 1'b1;
        state_d        = StWReq;
      end
      StCRd: begin
        cmd_o.child_chk = 1'b1;
        state_d         = StCVal;
      end
      StCVal: begin
        if (sts_i.create) begin
          cmd_o.node_new = 1'b1;
          if (sts_i.cur_odd) begin
            state_d = StFin;
          end else begin
            // second walk finds the suffix link of the new node
            cmd_o.walk2_start = 1'b1;
            phase2_d          = 1'b1;
            state_d           = StWLen;
          end
        end else begin
          cmd_o.node_old = 1'b1;
          state_d        = StFin;
        end
      end
      StURd: begin
        cmd_o.link_wr = 1'b1;
        state_d       = StFin;
      end
      StFin: begin
        if (out_free) begin
          cmd_o.fin_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StWipe;
      phase2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase2_q    <= phase2_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* src/palindromic_tree_append.sv */
// a clear, a refused or an ignored item goes straight to the result; an append walks the
// suffix links from the last node, and a new node that is not a child of the odd root takes a
// second walk for its suffix link; items are taken one at a time
// reset: async active low, then a clearing pass zeroes the child table with the input stalled;
// later clears leave stale entries, which are rejected by checking the child's parent and letter
module palindromic_tree_append import pta_pkg::*; #(
  parameter int unsigned MAX_LEN  = 4096,
  parameter int unsigned ALPHABET = 26
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  pta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pta_datapath #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

/* src/pta_checker.sv */
// port-level checks for palindromic_tree_append, bound to the top level
// depends on pta_pkg
module pta_checker import pta_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_full_no_create: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.store_full |-> !out_data_o.node_created)
    else $error("refused append reports a new node");

  a_create_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.node_created |-> out_data_o.suffix_node > ResW'(1))
    else $error("new node is a root");

  a_node_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.suffix_node > ResW'(1) |->
      out_data_o.suffix_palindrome_length != '0)
    else $error("tree node with zero length");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transfer taken while busy");

endmodule

bind palindromic_tree_append pta_checker u_pta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
